### hdl/bpc_pkg.sv
package bpc_pkg;

	// Button map, in handling order
	localparam int NUM_BUTTONS = 10;
	localparam int NUM_MEM     = 3;
	localparam int NUM_DIGITS  = 5;
	localparam int BTN_START   = 0;
	localparam int BTN_CLEAR   = 1;
	localparam int BTN_MEM0    = 2;
	localparam int BTN_DIGIT0  = 5;

	localparam int CNT_W     = 8;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SHORT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT = 2'd2;

	localparam logic [CNT_W-1:0] SHORT_RESET  = 8'd2;
	localparam logic [CNT_W-1:0] LONG_RESET   = 8'd100;
	localparam logic [CNT_W-1:0] REPEAT_RESET = 8'd50;

	typedef struct packed {
		logic [NUM_BUTTONS-1:0] buttons_pressed;
		logic                   mode_load;
		logic [2:0]             mode_value;
	} in_item_t;

	typedef struct packed {
		logic [2:0]            mode;
		logic [NUM_DIGITS-1:0] digit_step;
		logic [NUM_MEM-1:0]    memory_recall;
		logic [NUM_MEM-1:0]    memory_store;
		logic                  count_clear;
		logic                  prescaler_restart;
		logic                  power_off_request;
		logic                  display_refresh;
		logic                  memory_area_refresh;
	} out_item_t;

	// Classified press events of one tick, handed from front to back
	typedef struct packed {
		logic                  mode_load;
		logic [2:0]            mode_value;
		logic                  start_hit;
		logic                  clear_short;
		logic                  clear_long;
		logic [NUM_MEM-1:0]    mem_short;
		logic [NUM_MEM-1:0]    mem_long;
		logic [NUM_DIGITS-1:0] digit_step;
	} event_t;

endpackage

### hdl/bpc_stream_if.sv
interface bpc_stream_if #(
	parameter type payload_t = logic
);

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (
		output valid,
		output payload,
		input  ready
	);

	modport sink (
		input  valid,
		input  payload,
		output ready
	);

endinterface

### hdl/bpc_front.sv
module bpc_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bpc_pkg::CNT_W-1:0]         cfg_wdata,
	bpc_stream_if.sink                        items,
	output logic                              evt_valid,
	output bpc_pkg::event_t                   evt,
	input  logic                              evt_ready
);

	import bpc_pkg::*;

	logic [CNT_W-1:0] short_q;
	logic [CNT_W-1:0] long_q;
	logic [CNT_W-1:0] repeat_q;
	logic [CNT_W-1:0] hold_q [NUM_BUTTONS];
	logic [CNT_W-1:0] hold_next [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] pressed;
	logic accept;

	assign pressed     = items.payload.buttons_pressed;
	assign items.ready = evt_ready;
	assign evt_valid   = items.valid;
	assign accept      = items.valid & evt_ready;

	// Write threshold registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_q  <= SHORT_RESET;
			long_q   <= LONG_RESET;
			repeat_q <= REPEAT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SHORT:  short_q  <= cfg_wdata;
				REG_LONG:   long_q   <= cfg_wdata;
				REG_REPEAT: repeat_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Classify each button against the thresholds and advance its counter
	always_comb begin
		logic [CNT_W-1:0] base;
		evt            = '0;
		evt.mode_load  = items.payload.mode_load;
		evt.mode_value = items.payload.mode_value;
		base           = '0;

		// start: counts up to one past short, then holds
		hold_next[BTN_START] = '0;
		if (pressed[BTN_START]) begin
			evt.start_hit = (hold_q[BTN_START] == short_q);
			hold_next[BTN_START] = (hold_q[BTN_START] <= short_q) ?
				hold_q[BTN_START] + 1'b1 : hold_q[BTN_START];
		end

		// clear: short and long actions, counts up to one past long
		hold_next[BTN_CLEAR] = '0;
		if (pressed[BTN_CLEAR]) begin
			evt.clear_short = (hold_q[BTN_CLEAR] == short_q);
			evt.clear_long  = (hold_q[BTN_CLEAR] == long_q);
			hold_next[BTN_CLEAR] = (hold_q[BTN_CLEAR] <= long_q) ?
				hold_q[BTN_CLEAR] + 1'b1 : hold_q[BTN_CLEAR];
		end

		// memory buttons: same counting as clear
		for (int i = 0; i < NUM_MEM; i++) begin
			hold_next[BTN_MEM0+i] = '0;
			if (pressed[BTN_MEM0+i]) begin
				evt.mem_short[i] = (hold_q[BTN_MEM0+i] == short_q);
				evt.mem_long[i]  = (hold_q[BTN_MEM0+i] == long_q);
				hold_next[BTN_MEM0+i] = (hold_q[BTN_MEM0+i] <= long_q) ?
					hold_q[BTN_MEM0+i] + 1'b1 : hold_q[BTN_MEM0+i];
			end
		end

		// digit buttons: step at short, repeat by falling back to short
		for (int i = 0; i < NUM_DIGITS; i++) begin
			hold_next[BTN_DIGIT0+i] = '0;
			if (pressed[BTN_DIGIT0+i]) begin
				evt.digit_step[i] = (hold_q[BTN_DIGIT0+i] == short_q) ||
					(hold_q[BTN_DIGIT0+i] == repeat_q);
				base = (hold_q[BTN_DIGIT0+i] == repeat_q) ? short_q :
					hold_q[BTN_DIGIT0+i];
				hold_next[BTN_DIGIT0+i] = base + 1'b1;
			end
		end
	end

	// Advance hold counters on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				hold_q[i] <= '0;
			end
		end else if (accept) begin
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				hold_q[i] <= hold_next[i];
			end
		end
	end

endmodule

### hdl/bpc_queue.sv
module bpc_queue #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	input  bpc_pkg::event_t push_data,
	output logic            push_ready,
	output logic            pop_valid,
	output bpc_pkg::event_t pop_data,
	input  logic            pop_ready
);

	import bpc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_QW = $clog2(DEPTH + 1);

	event_t            entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_QW-1:0] count_q;
	logic              push;
	logic              pop;

	assign push_ready = (count_q != CNT_QW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign push       = push_valid & push_ready;
	assign pop        = pop_valid & pop_ready;

	// Store pushed beats
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hdl/bpc_back.sv
module bpc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            evt_valid,
	input  bpc_pkg::event_t evt,
	output logic            evt_ready,
	bpc_stream_if.source    results
);

	import bpc_pkg::*;

	typedef enum logic [2:0] {
		MODE_SLEEP    = 3'd0,
		MODE_STOPPED  = 3'd1,
		MODE_ACTIVE   = 3'd2,
		MODE_SETMEM1  = 3'd3,
		MODE_SETMEM2  = 3'd4,
		MODE_SETMEM3  = 3'd5,
		MODE_END_BEEP = 3'd6,
		MODE_END_DONE = 3'd7
	} mode_t;

	mode_t     mode_q;
	mode_t     mode_next;
	out_item_t result_q;
	out_item_t result_next;
	logic      out_valid_q;
	logic      take;

	assign evt_ready       = !out_valid_q || results.ready;
	assign take            = evt_valid && evt_ready;
	assign results.valid   = out_valid_q;
	assign results.payload = result_q;

	// Apply the tick's events in button order to the mode machine
	always_comb begin
		mode_t m;
		result_next = '0;
		m = evt.mode_load ? mode_t'(evt.mode_value) : mode_q;

		// start, short press
		if (evt.start_hit) begin
			unique case (m) inside
				MODE_SLEEP: m = MODE_STOPPED;
				MODE_STOPPED: begin
					result_next.prescaler_restart = 1'b1;
					m = MODE_ACTIVE;
				end
				MODE_ACTIVE: m = MODE_STOPPED;
				MODE_SETMEM1, MODE_SETMEM2, MODE_SETMEM3: begin
					result_next.memory_store = NUM_MEM'(1) << 2'(m - MODE_SETMEM1);
					result_next.memory_area_refresh = 1'b1;
					result_next.display_refresh = 1'b1;
					m = MODE_STOPPED;
				end
				MODE_END_BEEP, MODE_END_DONE: begin
					result_next.display_refresh = 1'b1;
					m = MODE_STOPPED;
				end
			endcase
		end

		// clear, short press
		if (evt.clear_short) begin
			unique case (m) inside
				MODE_SLEEP, MODE_STOPPED: begin
					m = MODE_STOPPED;
					result_next.count_clear = 1'b1;
					result_next.display_refresh = 1'b1;
				end
				MODE_ACTIVE: ;
				MODE_SETMEM1, MODE_SETMEM2, MODE_SETMEM3: begin
					m = MODE_STOPPED;
					result_next.memory_area_refresh = 1'b1;
					result_next.display_refresh = 1'b1;
				end
				MODE_END_BEEP, MODE_END_DONE: begin
					result_next.display_refresh = 1'b1;
					m = MODE_STOPPED;
				end
			endcase
		end

		// clear, long press
		result_next.power_off_request = evt.clear_long;

		// memory buttons: recall on short, enter set mode on long if stopped
		for (int i = 0; i < NUM_MEM; i++) begin
			if (evt.mem_short[i]) begin
				result_next.memory_recall[i] = 1'b1;
				result_next.display_refresh = 1'b1;
			end
			if (evt.mem_long[i] && (m == MODE_STOPPED)) begin
				m = mode_t'(MODE_SETMEM1 + 3'(i));
				result_next.memory_area_refresh = 1'b1;
				result_next.display_refresh = 1'b1;
			end
		end

		// digit buttons
		result_next.digit_step = evt.digit_step;
		if (evt.digit_step != '0) begin
			result_next.display_refresh = 1'b1;
		end

		result_next.mode = m;
		mode_next = m;
	end

	// Hold mode and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_STOPPED;
			out_valid_q <= 1'b0;
		end else if (take) begin
			mode_q      <= mode_next;
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load result payload on each taken beat
	always_ff @(posedge clk) begin
		if (take) begin
			result_q <= result_next;
		end
	end

endmodule

### hdl/button_panel_press_classifier.sv
// An accepted input beat is pushed into the event queue; the back end pops it and loads
// its result into the output register. Throughput: one tick per cycle unless the queue is
// full or the output is stalled; the front counter update and back mode step are each
// registered, and the event queue of QUEUE_DEPTH entries lets either side stall alone.
// Reset: hold counters zero, mode stopped, thresholds short 2 / long 100 / repeat 50,
// event queue and output register empty.
module button_panel_press_classifier #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bpc_pkg::CNT_W-1:0]     cfg_wdata,
	bpc_stream_if.sink                    items,
	bpc_stream_if.source                  results
);

	import bpc_pkg::*;

	logic   front_valid;
	logic   front_ready;
	event_t front_evt;
	logic   back_valid;
	logic   back_ready;
	event_t back_evt;

	// Count holds and classify presses
	bpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.items     (items),
		.evt_valid (front_valid),
		.evt       (front_evt),
		.evt_ready (front_ready)
	);

	// Decouple front from back
	bpc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_data  (front_evt),
		.push_ready (front_ready),
		.pop_valid  (back_valid),
		.pop_data   (back_evt),
		.pop_ready  (back_ready)
	);

	// Run the mode machine and emit command pulses
	bpc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (back_valid),
		.evt       (back_evt),
		.evt_ready (back_ready),
		.results   (results)
	);

endmodule
